FILE: src/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property holds on every clock edge outside reset
`define FTRI_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("ftri assertion failed");
// antecedent on one edge implies consequent on the next edge
`define FTRI_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("ftri assertion failed");
`else
`define FTRI_ASSERT(label, prop)
`define FTRI_ASSERT_NEXT(label, pre, post)
`endif
`endif

FILE: src/ftri_pkg.sv
// shared types, codes and helper functions of the face list triangulator
package ftri_pkg;

	localparam int DataW = 8;
	localparam int VertW = 32;
	localparam int CfgAddrW = 3;
	localparam int CfgDataW = 32;

	// configuration register indexes
	localparam logic [CfgAddrW-1:0] REG_BIG_ENDIAN  = 3'd0;
	localparam logic [CfgAddrW-1:0] REG_COUNT_TYPE  = 3'd1;
	localparam logic [CfgAddrW-1:0] REG_INDEX_TYPE  = 3'd2;
	localparam logic [CfgAddrW-1:0] REG_SKIP_BEFORE = 3'd3;
	localparam logic [CfgAddrW-1:0] REG_SKIP_AFTER  = 3'd4;
	localparam logic [CfgAddrW-1:0] REG_FACE_COUNT  = 3'd5;

	// integer type codes
	localparam logic [2:0] TYPE_INT8   = 3'd0;
	localparam logic [2:0] TYPE_UINT8  = 3'd1;
	localparam logic [2:0] TYPE_INT16  = 3'd2;
	localparam logic [2:0] TYPE_UINT16 = 3'd3;
	localparam logic [2:0] TYPE_INT32  = 3'd4;
	localparam logic [2:0] TYPE_UINT32 = 3'd5;

	// parser phase codes
	localparam logic [2:0] PH_SKIP_BEFORE = 3'd0;
	localparam logic [2:0] PH_COUNT       = 3'd1;
	localparam logic [2:0] PH_INDEX       = 3'd2;
	localparam logic [2:0] PH_SKIP_AFTER  = 3'd3;
	localparam logic [2:0] PH_DONE        = 3'd4;

	typedef struct packed {
		logic             big_endian;
		logic [2:0]       len_type;
		logic [2:0]       index_type;
		logic [7:0]       skip_before;
		logic [7:0]       skip_after;
		logic [VertW-1:0] face_count;
	} cfg_t;

	typedef struct packed {
		logic             tri_valid;
		logic [VertW-1:0] vert_a;
		logic [VertW-1:0] vert_b;
		logic [VertW-1:0] vert_c;
		logic             element_done;
		logic             type_error;
	} res_t;

	typedef struct packed {
		logic main_valid;
		logic skid_valid;
	} obuf_stat_t;

	function automatic logic [2:0] type_bytes(input logic [2:0] t);
		logic [2:0] n;
		if (t < TYPE_INT16) begin
			n = 3'd1;
		end else if (t < TYPE_INT32) begin
			n = 3'd2;
		end else begin
			n = 3'd4;
		end
		return n;
	endfunction

	function automatic logic type_signed(input logic [2:0] t);
		return ~t[0];
	endfunction

	// sign or zero extend an accumulated value of type t
	function automatic logic [VertW-1:0] widen(input logic [VertW-1:0] v, input logic [2:0] t);
		logic [VertW-1:0] w;
		logic [2:0] n;
		n = type_bytes(t);
		w = v;
		if (n == 3'd1) begin
			w = {{24{type_signed(t) & v[7]}}, v[7:0]};
		end else if (n == 3'd2) begin
			w = {{16{type_signed(t) & v[15]}}, v[15:0]};
		end
		return w;
	endfunction

endpackage

FILE: src/ftri_parse.sv
// per-byte face parser: phase state, value assembly and fan triangle forming
module ftri_parse #(
	parameter int INDEX_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ftri_pkg::cfg_t        cfg,
	input  logic                  step_en,
	input  logic [7:0]            step_byte,
	input  logic                  step_restart,
	output logic                  res_valid,
	output ftri_pkg::res_t        res
);
	import ftri_pkg::*;

	logic [2:0]            phase_q, phase_d;
	logic [7:0]            bp_q, bp_d;
	logic [VertW-1:0]      acc_q, acc_d;
	logic [VertW-1:0]      faces_q, faces_d;
	logic [VertW-1:0]      left_q, left_d;
	logic [1:0]            seen_q, seen_d;
	logic [INDEX_BITS-1:0] apex_q, apex_d;
	logic [INDEX_BITS-1:0] prev_q, prev_d;

	logic [2:0]            ph;
	logic [7:0]            bp;
	logic [VertW-1:0]      acc;
	logic [2:0]            take_type;
	logic [VertW-1:0]      acc_take;
	logic [7:0]            bp_inc;
	logic                  take_done;
	logic [VertW-1:0]      fs_inc;
	logic                  last_face;
	logic [VertW-1:0]      count_w;
	logic [VertW-1:0]      index_w;
	logic [INDEX_BITS-1:0] index_v;
	logic [VertW-1:0]      left_dec;
	logic                  bad_type;
	logic                  no_faces;
	res_t                  res_d;
	logic                  res_vld_d;

	// working view after the implicit skip-before exit
	always_comb begin
		ph  = phase_q;
		bp  = bp_q;
		acc = acc_q;
		if (phase_q == PH_SKIP_BEFORE && bp_q >= cfg.skip_before) begin
			ph  = PH_COUNT;
			bp  = '0;
			acc = '0;
		end
	end

	assign take_type = (ph == PH_COUNT) ? cfg.len_type : cfg.index_type;
	assign acc_take  = cfg.big_endian ? {acc[VertW-9:0], step_byte}
	                                  : (acc | (VertW'(step_byte) << {bp[1:0], 3'b000}));
	assign bp_inc    = bp + 8'd1;
	assign take_done = bp_inc >= 8'(type_bytes(take_type));
	assign fs_inc    = faces_q + VertW'(1);
	assign last_face = fs_inc >= cfg.face_count;
	assign left_dec  = left_q - VertW'(1);
	assign bad_type  = (cfg.len_type > TYPE_UINT32) || (cfg.index_type > TYPE_UINT32);
	assign no_faces  = faces_q >= cfg.face_count;
	assign index_w   = widen(acc_take, cfg.index_type);
	assign index_v   = index_w[INDEX_BITS-1:0];

	always_comb begin
		count_w = widen(acc_take, cfg.len_type);
		if (type_signed(cfg.len_type) && count_w[VertW-1]) begin
			count_w = '0;
		end
	end

	always_comb begin
		phase_d   = phase_q;
		bp_d      = bp_q;
		acc_d     = acc_q;
		faces_d   = faces_q;
		left_d    = left_q;
		seen_d    = seen_q;
		apex_d    = apex_q;
		prev_d    = prev_q;
		res_d     = '0;
		res_vld_d = 1'b0;
		if (step_en) begin
			priority if (step_restart) begin
				phase_d = PH_SKIP_BEFORE;
				bp_d    = '0;
				acc_d   = '0;
				faces_d = '0;
				left_d  = '0;
				seen_d  = '0;
				apex_d  = '0;
				prev_d  = '0;
			end else if (phase_q >= PH_DONE) begin
				phase_d = phase_q;
			end else if (bad_type) begin
				res_d.type_error = 1'b1;
				res_vld_d        = 1'b1;
			end else if (no_faces) begin
				phase_d            = PH_DONE;
				bp_d               = '0;
				res_d.element_done = 1'b1;
				res_vld_d          = 1'b1;
			end else begin
				phase_d = ph;
				bp_d    = bp;
				acc_d   = acc;
				unique case (ph)
					PH_SKIP_BEFORE: begin
						bp_d = bp_inc;
						if (bp_inc >= cfg.skip_before) begin
							phase_d = PH_COUNT;
							bp_d    = '0;
							acc_d   = '0;
						end
					end
					PH_COUNT: begin
						bp_d  = bp_inc;
						acc_d = acc_take;
						if (take_done) begin
							left_d = count_w;
							seen_d = '0;
							if (count_w == '0) begin
								phase_d = PH_SKIP_AFTER;
								bp_d    = '0;
								if (cfg.skip_after == '0) begin
									faces_d            = fs_inc;
									phase_d            = last_face ? PH_DONE : PH_SKIP_BEFORE;
									res_d.element_done = last_face;
								end
							end else begin
								phase_d = PH_INDEX;
								bp_d    = '0;
								acc_d   = '0;
							end
						end
					end
					PH_INDEX: begin
						bp_d  = bp_inc;
						acc_d = acc_take;
						if (take_done) begin
							priority if (seen_q == 2'd0) begin
								apex_d = index_v;
								seen_d = 2'd1;
							end else if (seen_q == 2'd1) begin
								prev_d = index_v;
								seen_d = 2'd2;
							end else begin
								res_d.tri_valid = 1'b1;
								res_d.vert_a    = VertW'(apex_q);
								res_d.vert_b    = VertW'(prev_q);
								res_d.vert_c    = VertW'(index_v);
								prev_d          = index_v;
							end
							left_d = left_dec;
							if (left_dec == '0) begin
								phase_d = PH_SKIP_AFTER;
								bp_d    = '0;
								if (cfg.skip_after == '0) begin
									faces_d            = fs_inc;
									phase_d            = last_face ? PH_DONE : PH_SKIP_BEFORE;
									res_d.element_done = last_face;
								end
							end else begin
								phase_d = PH_INDEX;
								bp_d    = '0;
								acc_d   = '0;
							end
						end
					end
					default: begin
						bp_d = bp_inc;
						if (bp_inc >= cfg.skip_after) begin
							faces_d            = fs_inc;
							bp_d               = '0;
							phase_d            = last_face ? PH_DONE : PH_SKIP_BEFORE;
							res_d.element_done = last_face;
						end
					end
				endcase
				res_vld_d = res_d.tri_valid | res_d.element_done;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SKIP_BEFORE;
			bp_q    <= '0;
			acc_q   <= '0;
			faces_q <= '0;
			left_q  <= '0;
			seen_q  <= '0;
			apex_q  <= '0;
			prev_q  <= '0;
		end else begin
			phase_q <= phase_d;
			bp_q    <= bp_d;
			acc_q   <= acc_d;
			faces_q <= faces_d;
			left_q  <= left_d;
			seen_q  <= seen_d;
			apex_q  <= apex_d;
			prev_q  <= prev_d;
		end
	end

	assign res_valid = res_vld_d;
	assign res       = res_d;

endmodule

FILE: src/ftri_outbuf.sv
// result register with a skid entry in front of the output stream
module ftri_outbuf (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  ftri_pkg::res_t         push_res,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [95:0]            m_tdata,
	output logic [2:0]             m_tuser,
	output ftri_pkg::obuf_stat_t   stat
);
	import ftri_pkg::*;

	logic main_valid_q;
	logic skid_valid_q;
	res_t main_q;
	res_t skid_q;
	logic pop;

	assign pop = main_valid_q & m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (main_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end else begin
				main_valid_q <= 1'b1;
			end
		end else if (pop) begin
			main_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				main_q <= skid_q;
			end
		end else if (push) begin
			if (main_valid_q && !pop) begin
				skid_q <= push_res;
			end else begin
				main_q <= push_res;
			end
		end
	end

	assign m_tvalid        = main_valid_q;
	assign m_tdata         = {main_q.vert_c, main_q.vert_b, main_q.vert_a};
	assign m_tuser         = {main_q.type_error, main_q.element_done, main_q.tri_valid};
	assign stat.main_valid = main_valid_q;
	assign stat.skid_valid = skid_valid_q;

endmodule

FILE: src/binary_face_list_fan_triangulator_core.sv
// top level of the binary face list fan triangulator
//
// channel   dir  handshake           payload
// s_*       in   s_tvalid/s_tready   tdata: data_byte; tuser: restart
// m_*       out  m_tvalid/m_tready   tdata: vert_a, vert_b, vert_c;
//                                    tuser: tri_valid, element_done, type_error
// cfg_*     in   cfg_we              cfg_addr selects register, cfg_wdata value
//
// one byte item per cycle sustained while the skid entry of the output buffer is empty;
// each item is held in the input register, is parsed by the phase logic and, if it
// yields a result, is registered into the output register, or into the skid entry when
// the output register is occupied and not popped. s_tready drops only while the skid entry is full.
// arst_n clears config to defaults, parser state and all valid flags.
`include "assert_macros.svh"

module binary_face_list_fan_triangulator_core #(
	parameter int INDEX_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// byte input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] restart
	// triangle result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,   // [31:0] vert_a, [63:32] vert_b, [95:64] vert_c
	output logic [2:0]  m_tuser,   // [0] tri_valid, [1] element_done, [2] type_error
	// configuration writes
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [31:0] cfg_wdata
);
	import ftri_pkg::*;

	cfg_t       cfg_q;
	obuf_stat_t ob_stat;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       restart_s1;

	logic       s_accept;
	logic       step_en;
	logic       res_valid;
	res_t       res;

	// configuration registers, to be written only while the block is idle; the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.big_endian  <= 1'b0;
			cfg_q.len_type    <= TYPE_UINT8;
			cfg_q.index_type  <= TYPE_INT32;
			cfg_q.skip_before <= '0;
			cfg_q.skip_after  <= '0;
			cfg_q.face_count  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_BIG_ENDIAN:  cfg_q.big_endian  <= cfg_wdata[0];
				REG_COUNT_TYPE:  cfg_q.len_type    <= cfg_wdata[2:0];
				REG_INDEX_TYPE:  cfg_q.index_type  <= cfg_wdata[2:0];
				REG_SKIP_BEFORE: cfg_q.skip_before <= cfg_wdata[7:0];
				REG_SKIP_AFTER:  cfg_q.skip_after  <= cfg_wdata[7:0];
				REG_FACE_COUNT:  cfg_q.face_count  <= cfg_wdata;
				default: begin
					// writes past the register list are dropped
				end
			endcase
		end
	end

	// input register: free whenever the output skid entry is empty, since the
	// held item is then consumed in the same cycle
	assign s_tready = ~ob_stat.skid_valid;
	assign s_accept = s_tvalid & s_tready;
	assign step_en  = valid_s1 & ~ob_stat.skid_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_accept) begin
			valid_s1 <= 1'b1;
		end else if (step_en) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			byte_s1    <= s_tdata;
			restart_s1 <= s_tuser;
		end
	end

	// phase tracking and triangle forming for the held byte
	ftri_parse #(
		.INDEX_BITS(INDEX_BITS)
	) u_parse (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.step_en      (step_en),
		.step_byte    (byte_s1),
		.step_restart (restart_s1),
		.res_valid    (res_valid),
		.res          (res)
	);

	// result register plus skid entry toward the consumer
	ftri_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (step_en & res_valid),
		.push_res (res),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.stat     (ob_stat)
	);

	// skid entry only fills behind an occupied result register
	`FTRI_ASSERT(a_skid_behind_main, !ob_stat.skid_valid || ob_stat.main_valid)
	// a type error result carries no triangle and no done flag
	`FTRI_ASSERT(a_err_alone, !(m_tvalid && m_tuser[2] && (m_tuser[0] || m_tuser[1])))
	// a type error result has all vertex fields cleared
	`FTRI_ASSERT(a_err_zero_data, !(m_tvalid && m_tuser[2]) || (m_tdata == '0))
	// a full skid entry with a stalled consumer stays full
	`FTRI_ASSERT_NEXT(a_skid_hold, ob_stat.skid_valid && !m_tready, ob_stat.skid_valid)

endmodule

FILE: dv/tb_binary_face_list_fan_triangulator_core.sv
`timescale 1ns / 1ps
// self-checking testbench for the binary face list fan triangulator core
module tb_binary_face_list_fan_triangulator_core;
	import ftri_pkg::*;

	localparam int IndexBits = 32;
	// generous bound, far above the slowest legal run
	localparam int CycleLimit = 500000;
	localparam int RandomItems = 60;
	// receiver hold-off long enough to back the block up into its input
	localparam int LongHold = 300;
	// cycles for an item still in the pipe to clear
	localparam int SettleCycles = 6;

	// type codes outside the legal range
	localparam logic [2:0] TYPE_BAD_LO = 3'd6;
	localparam logic [2:0] TYPE_BAD_HI = 3'd7;

	// predicts the triangle stream from the accepted bytes and checks the outputs
	class fan_tri_tracker;
		// register copies, reset values of the block
		bit        big_endian  = 1'b0;
		bit [2:0]  len_type    = TYPE_UINT8;
		bit [2:0]  index_type  = TYPE_INT32;
		bit [7:0]  skip_before = 8'd0;
		bit [7:0]  skip_after  = 8'd0;
		bit [31:0] face_count  = 32'd0;

		// parser state
		bit [2:0]  phase        = PH_SKIP_BEFORE;
		bit [7:0]  byte_pos     = 8'd0;
		bit [31:0] word_acc     = 32'd0;
		bit [31:0] faces_seen   = 32'd0;
		bit [31:0] indices_left = 32'd0;
		bit [1:0]  indices_seen = 2'd0;
		bit [31:0] apex_index   = 32'd0;
		bit [31:0] prev_index   = 32'd0;

		bit [31:0] imask = 32'hFFFF_FFFF >> (32 - IndexBits);

		res_t pending_tris[$];
		int n_items, n_tris, n_dones, n_type_errs, n_mismatches;

		function void clear_parser();
			phase = PH_SKIP_BEFORE;
			byte_pos = 8'd0;
			word_acc = 32'd0;
			faces_seen = 32'd0;
			indices_left = 32'd0;
			indices_seen = 2'd0;
			apex_index = 32'd0;
			prev_index = 32'd0;
		endfunction

		function int unsigned width_of(bit [2:0] t);
			if (t < TYPE_INT16) return 1;
			if (t < TYPE_INT32) return 2;
			return 4;
		endfunction

		// sign or zero extension by type, even codes are signed
		function bit [31:0] to_word(bit [31:0] v, bit [2:0] t);
			if (width_of(t) == 1) return {{24{~t[0] & v[7]}}, v[7:0]};
			if (width_of(t) == 2) return {{16{~t[0] & v[15]}}, v[15:0]};
			return v;
		endfunction

		// true once the value of type t is complete
		function bit shift_in(bit [7:0] b, bit [2:0] t);
			if (big_endian) begin
				word_acc = {word_acc[23:0], b};
			end else begin
				word_acc = word_acc | ({24'd0, b} << (8 * byte_pos[1:0]));
			end
			byte_pos = byte_pos + 8'd1;
			return byte_pos >= width_of(t);
		endfunction

		function void open_value(bit [2:0] ph);
			phase = ph;
			byte_pos = 8'd0;
			word_acc = 32'd0;
		endfunction

		function bit close_face();
			faces_seen = faces_seen + 32'd1;
			byte_pos = 8'd0;
			if (faces_seen >= face_count) begin
				phase = PH_DONE;
				return 1'b1;
			end
			phase = PH_SKIP_BEFORE;
			return 1'b0;
		endfunction

		function bit enter_trailer();
			phase = PH_SKIP_AFTER;
			byte_pos = 8'd0;
			if (skip_after == 8'd0) return close_face();
			return 1'b0;
		endfunction

		function void set_reg(bit [2:0] addr, bit [31:0] value);
			case (addr)
				REG_BIG_ENDIAN:  big_endian = value[0];
				REG_COUNT_TYPE:  len_type = value[2:0];
				REG_INDEX_TYPE:  index_type = value[2:0];
				REG_SKIP_BEFORE: skip_before = value[7:0];
				REG_SKIP_AFTER:  skip_after = value[7:0];
				REG_FACE_COUNT:  face_count = value;
				default: ;
			endcase
		endfunction

		function void note_result(res_t r);
			pending_tris = {pending_tris, r};
			n_tris += int'(r.tri_valid);
			n_dones += int'(r.element_done);
			n_type_errs += int'(r.type_error);
		endfunction

		function void accept_byte(bit [7:0] b, bit restart);
			res_t r;
			bit [31:0] v;
			bit tri_hit;
			bit done_hit;
			r = '0;
			tri_hit = 1'b0;
			done_hit = 1'b0;
			n_items++;
			if (restart) begin
				clear_parser();
				return;
			end
			if (phase >= PH_DONE) return;
			if (len_type > TYPE_UINT32 || index_type > TYPE_UINT32) begin
				r.type_error = 1'b1;
				note_result(r);
				return;
			end
			// face count reached, also when lowered below the faces already seen
			if (faces_seen >= face_count) begin
				phase = PH_DONE;
				byte_pos = 8'd0;
				r.element_done = 1'b1;
				note_result(r);
				return;
			end
			if (phase == PH_SKIP_BEFORE && byte_pos >= skip_before) open_value(PH_COUNT);
			case (phase)
				PH_SKIP_BEFORE: begin
					byte_pos = byte_pos + 8'd1;
					if (byte_pos >= skip_before) open_value(PH_COUNT);
				end
				PH_COUNT: begin
					if (shift_in(b, len_type)) begin
						v = to_word(word_acc, len_type);
						// negative signed count means an empty list
						if (!len_type[0] && v[31]) v = 32'd0;
						indices_left = v;
						indices_seen = 2'd0;
						if (v == 32'd0) done_hit = enter_trailer();
						else open_value(PH_INDEX);
					end
				end
				PH_INDEX: begin
					if (shift_in(b, index_type)) begin
						v = to_word(word_acc, index_type) & imask;
						if (indices_seen == 2'd0) begin
							apex_index = v;
							indices_seen = 2'd1;
						end else if (indices_seen == 2'd1) begin
							prev_index = v;
							indices_seen = 2'd2;
						end else begin
							tri_hit = 1'b1;
							r.vert_a = apex_index;
							r.vert_b = prev_index;
							r.vert_c = v;
							prev_index = v;
						end
						indices_left = indices_left - 32'd1;
						if (indices_left == 32'd0) done_hit = enter_trailer();
						else open_value(PH_INDEX);
					end
				end
				default: begin
					byte_pos = byte_pos + 8'd1;
					if (byte_pos >= skip_after) done_hit = close_face();
				end
			endcase
			if (tri_hit || done_hit) begin
				r.tri_valid = tri_hit;
				r.element_done = done_hit;
				note_result(r);
			end
		endfunction

		function void compare(string field, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %h, actual %h", field, want, got);
				n_mismatches++;
			end
		endfunction

		function void check_result(logic [95:0] data, logic [2:0] user);
			res_t want;
			if (pending_tris.size() == 0) begin
				$error("result with nothing expected: tdata %h tuser %b", data, user);
				n_mismatches++;
				return;
			end
			want = pending_tris.pop_front();
			compare("tri_valid", 32'(want.tri_valid), 32'(user[0]));
			compare("element_done", 32'(want.element_done), 32'(user[1]));
			compare("type_error", 32'(want.type_error), 32'(user[2]));
			compare("vert_a", want.vert_a, data[31:0]);
			compare("vert_b", want.vert_b, data[63:32]);
			compare("vert_c", want.vert_c, data[95:64]);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [95:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        cfg_we;
	logic [2:0]  cfg_addr;
	logic [31:0] cfg_wdata;

	// quiet: no idling on either side; steady: sender offers back to back
	bit quiet = 1'b0;
	bit steady = 1'b0;
	bit sink_hold_req = 1'b0;
	int cycle_count;
	int n_settings;

	fan_tri_tracker tracker = new();

	binary_face_list_fan_triangulator_core #(
		.INDEX_BITS(IndexBits)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// both handshakes are sampled at the edge, before any update of that edge lands
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) tracker.accept_byte(s_tdata, s_tuser);
			if (m_tvalid && m_tready) tracker.check_result(m_tdata, m_tuser);
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("Simulation FAILED");
		$finish;
	end

	// receiver: random ready bursts, random stalls, one long hold-off on request
	initial begin
		forever begin
			if (sink_hold_req) begin
				sink_hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (LongHold) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
		end
	end

	// offer one item and hold it until accepted, with an optional gap ahead of it
	task automatic push_item(input logic [7:0] b, input logic restart);
		if (!quiet && !steady && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= restart;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// send n bytes, the leftmost byte of the packed vector first
	task automatic push_bytes(input logic [127:0] bytes, input int n);
		for (int k = 0; k < n; k++) push_item(bytes[8 * (n - 1 - k) +: 8], 1'b0);
	endtask

	// stop offering, let every expected result arrive, then let the pipe drain
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		// wait for the next edge so the last accepted item is already in the prediction
		@(posedge clk);
		while (tracker.pending_tris.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [2:0] addr, input logic [31:0] value);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= value;
		@(posedge clk);
		tracker.set_reg(addr, value);
	endtask

	task automatic cfg_release();
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(input logic be, input logic [2:0] ct, input logic [2:0] it,
			input logic [7:0] sb, input logic [7:0] sa, input logic [31:0] fc);
		cfg_write(REG_BIG_ENDIAN, 32'(be));
		cfg_write(REG_COUNT_TYPE, 32'(ct));
		cfg_write(REG_INDEX_TYPE, 32'(it));
		cfg_write(REG_SKIP_BEFORE, 32'(sb));
		cfg_write(REG_SKIP_AFTER, 32'(sa));
		cfg_write(REG_FACE_COUNT, fc);
		cfg_release();
		n_settings++;
	endtask

	// encode a value of type t in the current byte order
	task automatic send_value(input logic [31:0] v, input logic [2:0] t);
		int n;
		int idx;
		n = tracker.width_of(t);
		for (int k = 0; k < n; k++) begin
			idx = tracker.big_endian ? n - 1 - k : k;
			push_item(v[8 * idx +: 8], 1'b0);
		end
	endtask

	// one well-formed face, the register values may change between its count and list
	task automatic send_face(input int unsigned nidx, input bit neg);
		logic [31:0] v;
		repeat (tracker.skip_before) push_item(8'($urandom), 1'b0);
		v = neg ? 32'd0 - $urandom_range(1, 100) : nidx;
		send_value(v, tracker.len_type);
		if (!steady && $urandom_range(0, 14) == 0) begin
			// mid-face register change while the block is idle
			wait_idle();
			case ($urandom_range(0, 3))
				0: cfg_write(REG_SKIP_AFTER, $urandom_range(0, 3));
				1: cfg_write(REG_SKIP_BEFORE, $urandom_range(0, 3));
				2: cfg_write(REG_BIG_ENDIAN, 32'(~tracker.big_endian));
				default: cfg_write(REG_FACE_COUNT, tracker.faces_seen + $urandom_range(0, 2));
			endcase
			cfg_release();
		end
		repeat (neg ? 0 : nidx) begin
			case ($urandom_range(0, 7))
				0: v = 32'h0000_0000;
				1: v = 32'hFFFF_FFFF;
				default: v = $urandom;
			endcase
			send_value(v, tracker.index_type);
		end
		repeat (tracker.skip_after) push_item(8'($urandom), 1'b0);
	endtask

	// one element under a random setting, mostly well formed faces plus some noise
	task automatic run_random_element();
		logic [31:0] fc;
		logic [2:0] ct;
		logic [2:0] it;
		int unsigned nfaces;
		int unsigned nidx;
		int pick;
		bit neg;
		wait_idle();
		case ($urandom_range(0, 7))
			0: fc = 32'hFFFF_FFFF;
			1: fc = $urandom;
			default: fc = $urandom_range(1, 6);
		endcase
		ct = 3'($urandom_range(TYPE_INT8, TYPE_UINT32));
		it = 3'($urandom_range(TYPE_INT8, TYPE_UINT32));
		set_config(1'($urandom_range(0, 1)), ct, it,
			8'(($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 3)),
			8'(($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 3)), fc);
		push_item(8'($urandom), 1'b1);
		nfaces = (fc <= 6) ? fc + $urandom_range(0, 1) : $urandom_range(2, 6);
		repeat (nfaces) begin
			pick = $urandom_range(0, 19);
			if (pick == 0) begin
				// restart partway through the element
				push_item(8'($urandom), 1'b1);
			end else if (pick == 1) begin
				// stray bytes knock the parser out of step
				repeat ($urandom_range(1, 4)) push_item(8'($urandom), 1'b0);
			end else if (pick == 2) begin
				// illegal type code for a byte or two, then back
				wait_idle();
				if ($urandom_range(0, 1)) cfg_write(REG_COUNT_TYPE, $urandom_range(TYPE_BAD_LO, TYPE_BAD_HI));
				else cfg_write(REG_INDEX_TYPE, $urandom_range(TYPE_BAD_LO, TYPE_BAD_HI));
				cfg_release();
				repeat ($urandom_range(1, 2)) push_item(8'($urandom), 1'b0);
				wait_idle();
				cfg_write(REG_COUNT_TYPE, 32'(ct));
				cfg_write(REG_INDEX_TYPE, 32'(it));
				cfg_release();
			end
			case ($urandom_range(0, 9))
				0: nidx = 0;
				1: nidx = 1;
				2: nidx = 2;
				default: nidx = $urandom_range(3, 8);
			endcase
			neg = !tracker.len_type[0] && $urandom_range(0, 9) == 0;
			send_face(nidx, neg);
		end
		// bytes after the last face are dropped once the element is done
		repeat ($urandom_range(0, 2)) push_item(8'($urandom), 1'b0);
	endtask

	initial begin
		int start_items;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= 8'h00;
		s_tuser <= 1'b0;
		cfg_we <= 1'b0;
		cfg_addr <= REG_BIG_ENDIAN;
		cfg_wdata <= 32'd0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset registers have zero faces: first byte flags done, next one is dropped
		push_item(8'h00, 1'b0);
		push_item(8'hFF, 1'b0);

		// big endian 16-bit count and index: a short face, then a triangle that ends
		// the element on the same item
		wait_idle();
		set_config(1'b1, TYPE_INT16, TYPE_UINT16, 8'd0, 8'd0, 32'd2);
		push_item(8'hFF, 1'b1);
		push_bytes(128'({8'h00, 8'h02, 8'hAB, 8'hCD, 8'h12, 8'h34,
			8'h00, 8'h03, 8'hFF, 8'hFF, 8'h00, 8'h01, 8'h80, 8'h00}), 14);

		// illegal count type, then illegal index type, state is kept through both
		wait_idle();
		set_config(1'b0, TYPE_BAD_HI, TYPE_BAD_LO, 8'd1, 8'd1, 32'd2);
		push_item(8'h00, 1'b1);
		push_item(8'h5A, 1'b0);
		wait_idle();
		cfg_write(REG_COUNT_TYPE, 32'(TYPE_INT8));
		cfg_release();
		push_item(8'h5A, 1'b0);
		wait_idle();
		cfg_write(REG_INDEX_TYPE, 32'(TYPE_INT8));
		cfg_release();

		// signed 8-bit indices with sign extension, then a negative count
		push_bytes(128'({8'h55, 8'h03, 8'h80, 8'h7F, 8'hFF, 8'hAA, 8'h66, 8'hF0, 8'hBB}), 9);

		// widest skips around one small face
		wait_idle();
		set_config(1'b0, TYPE_UINT32, TYPE_UINT8, 8'd255, 8'd255, 32'd1);
		push_item(8'h00, 1'b1);
		send_face(3, 1'b0);

		// long receiver hold while the sender keeps offering, fills the block
		wait_idle();
		set_config(1'b0, TYPE_UINT8, TYPE_UINT8, 8'd0, 8'd0, 32'hFFFF_FFFF);
		push_item(8'h00, 1'b1);
		sink_hold_req = 1'b1;
		steady = 1'b1;
		send_face(40, 1'b0);
		steady = 1'b0;
		// sender pauses here until every triangle has come out
		wait_idle();

		start_items = tracker.n_items;
		while (tracker.n_items - start_items < RandomItems) run_random_element();

		// closing stretch with no idling on either side
		quiet = 1'b1;
		repeat (2) run_random_element();

		wait_idle();
		repeat (SettleCycles) @(posedge clk);

		$display("run covered %0d input items over %0d register settings",
			tracker.n_items, n_settings);
		$display("checked %0d triangles, %0d element ends, %0d type errors, %0d mismatches",
			tracker.n_tris, tracker.n_dones, tracker.n_type_errs, tracker.n_mismatches);
		if (tracker.n_mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
